@@ design/sa_pkg.sv @@
// Shared types, codes and constants of the stack allocator.
// No dependencies; every other design file imports this package.
package sa_pkg;

  // Default sizing of the allocator
  localparam int unsigned ARENA_BYTES_DEF       = 65536;
  localparam int unsigned MAX_BLOCKS_DEF        = 64;
  localparam int unsigned HEADER_POS_BYTES_DEF  = 4;
  localparam int unsigned HEADER_SIZE_BYTES_DEF = 4;

  // Field widths fixed by the interface
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned ARENA_W  = 17;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned ALOG_W   = 4;
  localparam int unsigned SKEW_W   = 12;
  localparam int unsigned CFG_IDX_W = 2;
  // Largest alignment is 2**15, so only the low 15 address bits set the pad
  localparam int unsigned ALIGN_W  = (1 << ALOG_W) - 1;
  // New top: limit + max pad + headers + size stays below 2**19
  localparam int unsigned NT_W     = ARENA_W + 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARENA_BYTES  = 2'd1;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_NOT_NEWEST = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  // One header store entry: header position offset and data size
  typedef struct packed {
    logic [ARENA_W-1:0] pos;
    logic [SIZE_W-1:0]  size;
  } hdr_t;

  // Configuration seen by the engine
  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [ARENA_W-1:0] arena;
  } cfg_t;

endpackage

@@ design/sa_hdr_mem.sv @@
// Header store: single-port-write, single-port-read synchronous RAM with
// registered read data. Depends on sa_pkg for the entry type.
module sa_hdr_mem #(
  parameter int unsigned DEPTH = sa_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [IDX_W-1:0]  rd_addr_i,
  output sa_pkg::hdr_t      rd_data_o,
  input  logic              wr_en_i,
  input  logic [IDX_W-1:0]  wr_addr_i,
  input  sa_pkg::hdr_t      wr_data_i
);
  import sa_pkg::*;

  hdr_t mem_q [DEPTH];
  hdr_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/sa_engine.sv @@
// Request sequencer and datapath: top pointer, block count, header store
// access and the result register. Depends on sa_pkg and sa_hdr_mem.
module sa_engine #(
  parameter int unsigned ARENA_BYTES       = sa_pkg::ARENA_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS        = sa_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned HEADER_POS_BYTES  = sa_pkg::HEADER_POS_BYTES_DEF,
  parameter int unsigned HEADER_SIZE_BYTES = sa_pkg::HEADER_SIZE_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sa_pkg::cfg_t                 cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         opcode_i,
  input  logic [sa_pkg::SIZE_W-1:0]    size_i,
  input  logic [sa_pkg::ALOG_W-1:0]    alignment_log2_i,
  input  logic [sa_pkg::SKEW_W-1:0]    skew_i,
  input  logic [sa_pkg::ADDR_W-1:0]    address_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sa_pkg::ADDR_W-1:0]    result_address_o,
  output logic [1:0]                   status_o,
  output logic [sa_pkg::ARENA_W-1:0]   used_bytes_o
);
  import sa_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned HDR_BYTES = HEADER_POS_BYTES + HEADER_SIZE_BYTES;
  localparam logic [NT_W-1:0] HDR_NT = NT_W'(HDR_BYTES);
  localparam logic [ADDR_W-1:0] HDR_A = ADDR_W'(HDR_BYTES);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);
  // Limit cap from the build-time arena size, clipped to the register range
  localparam logic [NT_W-1:0] CAP = (ARENA_BYTES >= (1 << ARENA_W)) ?
                                    NT_W'((1 << ARENA_W) - 1) : NT_W'(ARENA_BYTES);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [ARENA_W-1:0] top_q;
  logic [CNT_W-1:0]   count_q;

  // Latched request
  logic               op_q;
  logic [SIZE_W-1:0]  size_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [ALIGN_W-1:0] pad_q;

  // Result register
  logic               out_valid_q;
  logic [ADDR_W-1:0]  res_addr_q;
  logic [1:0]         status_q;
  logic [ARENA_W-1:0] used_q;

  logic accept, done;
  logic [ALIGN_W-1:0] pad_d, amask, xlow;

  hdr_t rd_hdr, wr_hdr;
  logic wr_en;

  logic [NT_W-1:0]    pos_off, new_top, limit;
  logic               full, ovf, empty, match;
  logic [ADDR_W-1:0]  alloc_addr, free_addr;
  logic [1:0]         status_d;
  logic [ADDR_W-1:0]  res_addr_d;
  logic [ARENA_W-1:0] top_d;
  logic [CNT_W-1:0]   count_d;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign done   = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (state_q != S_IDLE);

  // Alignment pad from the low address bits at accept time
  always_comb begin
    amask = ALIGN_W'((({(ALIGN_W + 1){1'b0}} | (ALIGN_W + 1)'(1)) << alignment_log2_i)
                     - (ALIGN_W + 1)'(1));
    xlow  = cfg_i.base[ALIGN_W-1:0] + top_q[ALIGN_W-1:0] + ALIGN_W'(skew_i);
    pad_d = (~xlow + ALIGN_W'(1)) & amask;
  end

  // Header store; read the newest entry when a request is taken
  sa_hdr_mem #(
    .DEPTH (MAX_BLOCKS),
    .IDX_W (IDX_W)
  ) u_hdr_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (IDX_W'(count_q - CNT_W'(1))),
    .rd_data_o (rd_hdr),
    .wr_en_i   (wr_en),
    .wr_addr_i (IDX_W'(count_q)),
    .wr_data_i (wr_hdr)
  );

  // Evaluate the latched request
  always_comb begin
    limit      = (NT_W'(cfg_i.arena) < CAP) ? NT_W'(cfg_i.arena) : CAP;
    pos_off    = NT_W'(top_q) + NT_W'(pad_q);
    new_top    = pos_off + HDR_NT + NT_W'(size_q);
    full       = (count_q == CNT_MAX);
    ovf        = (new_top > limit);
    empty      = (count_q == '0);
    alloc_addr = cfg_i.base + ADDR_W'(pos_off) + HDR_A;
    free_addr  = cfg_i.base + ADDR_W'(rd_hdr.pos) + HDR_A;
    match      = (free_addr == addr_q);
    wr_hdr.pos  = ARENA_W'(pos_off);
    wr_hdr.size = size_q;
    wr_en      = 1'b0;
    top_d      = top_q;
    count_d    = count_q;
    res_addr_d = '0;
    status_d   = STAT_OK;
    if (op_q == OP_ALLOC) begin
      if (full) begin
        status_d = STAT_FULL;
      end else if (ovf) begin
        status_d = STAT_OVERFLOW;
      end else begin
        wr_en      = done;
        top_d      = ARENA_W'(new_top);
        count_d    = count_q + CNT_W'(1);
        res_addr_d = alloc_addr;
      end
    end else begin
      if (empty || !match) begin
        status_d = STAT_NOT_NEWEST;
      end else begin
        top_d   = rd_hdr.pos;
        count_d = count_q - CNT_W'(1);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (done) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      top_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (done) begin
        top_q       <= top_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the request fields while it is worked on
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      size_q <= size_i;
      addr_q <= address_i;
      pad_q  <= pad_d;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (done) begin
      res_addr_q <= res_addr_d;
      status_q   <= status_d;
      used_q     <= top_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_address_o = res_addr_q;
  assign status_o         = status_q;
  assign used_bytes_o     = used_q;

endmodule

@@ design/stack_allocator_with_headers.sv @@
// Top level of the stack allocator: configuration registers and engine.
// Depends on sa_pkg and sa_engine.

// LIFO allocator over one arena. Each request is accepted in S_IDLE, in which
// the header store reads its newest entry and the alignment pad is formed,
// and is then handled in S_EXEC, which checks it against the store read data
// and the limit and loads the result register. The next request is taken in
// the cycle after that load, even while the result still waits at the output;
// a stalled output that still holds a result keeps the engine in S_EXEC.
// Headers live in a MAX_BLOCKS-deep RAM; its read data is only used for
// entries that an allocate has written, so it needs no clearing after reset.
// Write the configuration only while no request is in flight.
module stack_allocator_with_headers #(
  parameter int unsigned ARENA_BYTES       = sa_pkg::ARENA_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS        = sa_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned HEADER_POS_BYTES  = sa_pkg::HEADER_POS_BYTES_DEF,
  parameter int unsigned HEADER_SIZE_BYTES = sa_pkg::HEADER_SIZE_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sa_pkg::ADDR_W-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           opcode_i,
  input  logic [sa_pkg::SIZE_W-1:0]      size_i,
  input  logic [sa_pkg::ALOG_W-1:0]      alignment_log2_i,
  input  logic [sa_pkg::SKEW_W-1:0]      skew_i,
  input  logic [sa_pkg::ADDR_W-1:0]      address_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sa_pkg::ADDR_W-1:0]      result_address_o,
  output logic [1:0]                     status_o,
  output logic [sa_pkg::ARENA_W-1:0]     used_bytes_o
);
  import sa_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base  <= '0;
      cfg_q.arena <= ARENA_W'(ARENA_BYTES_DEF);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_BASE_ADDRESS: cfg_q.base  <= cfg_data_i;
        CFG_ARENA_BYTES:  cfg_q.arena <= cfg_data_i[ARENA_W-1:0];
        default: ;
      endcase
    end
  end

  sa_engine #(
    .ARENA_BYTES       (ARENA_BYTES),
    .MAX_BLOCKS        (MAX_BLOCKS),
    .HEADER_POS_BYTES  (HEADER_POS_BYTES),
    .HEADER_SIZE_BYTES (HEADER_SIZE_BYTES)
  ) u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .size_i           (size_i),
    .alignment_log2_i (alignment_log2_i),
    .skew_i           (skew_i),
    .address_i        (address_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_address_o (result_address_o),
    .status_o         (status_o),
    .used_bytes_o     (used_bytes_o)
  );

endmodule

@@ design/sa_checker.sv @@
// Port-level assertions of the stack allocator, bound to the top level.
// Depends on sa_pkg and stack_allocator_with_headers.
module sa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [sa_pkg::ADDR_W-1:0]    result_address_o,
  input logic [1:0]                   status_o
);
  import sa_pkg::*;

  // Busy for the cycle after a request is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepted transaction");

  // A new result only appears while a request was being worked on
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no request in flight");

  // Failed requests return a zero address; frees also return zero, but only errors are checked here
  a_error_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_OK) |-> (result_address_o == '0))
    else $error("nonzero address on error result");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_address_o)
      && $stable(status_o))
    else $error("stalled result transaction changed");

endmodule

bind stack_allocator_with_headers sa_checker u_sa_checker (.*);

@@ verif/tb_stack_allocator_with_headers.sv @@
// Self-checking testbench for the stack allocator with headers.
// Depends on sa_pkg and stack_allocator_with_headers; drives directed rows,
// then phases of random requests under several arena settings.
`timescale 1ns / 100ps

module tb_stack_allocator_with_headers;
  import sa_pkg::*;

  localparam int unsigned HDR_BYTES   = HEADER_POS_BYTES_DEF + HEADER_SIZE_BYTES_DEF;
  localparam int unsigned ARENA_LIMIT = ARENA_BYTES_DEF;
  localparam int unsigned MAX_BLOCKS  = MAX_BLOCKS_DEF;
  localparam int          NUM_ROWS    = 19;
  localparam int          NUM_PHASES  = 6;

  typedef struct packed {
    opcode_e            op;
    logic [SIZE_W-1:0]  size;
    logic [ALOG_W-1:0]  alog;
    logic [SKEW_W-1:0]  skew;
    logic [ADDR_W-1:0]  addr;
  } request_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [1:0]         status;
    logic [ARENA_W-1:0] used;
  } reply_t;

  // One directed row: free to the newest block if to_newest, typed reply if typed
  typedef struct packed {
    request_t req;
    logic     to_newest;
    logic     typed;
    reply_t   want;
  } row_t;

  typedef struct {
    logic [ADDR_W-1:0]  base;
    logic [ARENA_W-1:0] arena;
    int                 items;
    int                 alloc_pct;
    bit                 wide;
  } phase_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [ADDR_W-1:0]     cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  opcode_i;
  logic [SIZE_W-1:0]     size_i;
  logic [ALOG_W-1:0]     alignment_log2_i;
  logic [SKEW_W-1:0]     skew_i;
  logic [ADDR_W-1:0]     address_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [ADDR_W-1:0]     result_address_o;
  logic [1:0]            status_o;
  logic [ARENA_W-1:0]    used_bytes_o;

  // Allocator state as the testbench tracks it
  logic [ADDR_W-1:0]     cfg_base;
  logic [ARENA_W-1:0]    cfg_arena;
  logic [ARENA_W-1:0]    top_ofs;
  logic [ARENA_W-1:0]    blk_pos [MAX_BLOCKS];
  int unsigned           live_blocks;

  reply_t                pending_replies [$];
  row_t                  dir_rows [NUM_ROWS];
  phase_t                phases [NUM_PHASES];
  int                    mismatches;
  int                    results_seen;
  bit                    tx_idle_on;
  bit                    rx_idle_on;

  stack_allocator_with_headers DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .size_i           (size_i),
    .alignment_log2_i (alignment_log2_i),
    .skew_i           (skew_i),
    .address_i        (address_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_address_o (result_address_o),
    .status_o         (status_o),
    .used_bytes_o     (used_bytes_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Bound the run well past the slowest legal schedule
  initial begin
    #4_000_000;
    $display("stack_allocator_with_headers verification failed");
    $finish;
  end

  // Data address of the newest live block under the current base
  function automatic logic [ADDR_W-1:0] newest_data_address();
    if (live_blocks == 0) return '0;
    return 32'(64'(cfg_base) + 64'(blk_pos[live_blocks-1]) + 64'(HDR_BYTES));
  endfunction

  // Advance the tracked allocator by one request and return its reply
  function automatic reply_t apply_request(input request_t r);
    reply_t      rep;
    logic [63:0] align;
    logic [63:0] spot;
    logic [63:0] pos_off;
    logic [63:0] new_top;
    logic [63:0] limit;
    rep = '0;
    limit = (cfg_arena > ARENA_LIMIT) ? 64'(ARENA_LIMIT) : 64'(cfg_arena);
    if (r.op == OP_ALLOC) begin
      if (live_blocks >= MAX_BLOCKS) begin
        rep.status = STAT_FULL;
      end else begin
        align   = 64'd1 << r.alog;
        spot    = 64'(cfg_base) + 64'(top_ofs) + 64'(r.skew);
        spot    = ((spot + align - 64'd1) & ~(align - 64'd1)) - 64'(r.skew);
        pos_off = spot - 64'(cfg_base);
        new_top = pos_off + 64'(HDR_BYTES) + 64'(r.size);
        if (new_top > limit) begin
          rep.status = STAT_OVERFLOW;
        end else begin
          blk_pos[live_blocks] = pos_off[ARENA_W-1:0];
          live_blocks++;
          top_ofs  = new_top[ARENA_W-1:0];
          rep.addr = 32'(spot + 64'(HDR_BYTES));
        end
      end
    end else if (live_blocks == 0 || r.addr != newest_data_address()) begin
      rep.status = STAT_NOT_NEWEST;
    end else begin
      live_blocks--;
      top_ofs = blk_pos[live_blocks];
    end
    rep.used = top_ofs;
    return rep;
  endfunction

  // Random request; frees mostly name the newest block, some miss by one bit
  function automatic request_t draw_request(input int alloc_pct, input bit wide);
    request_t r;
    r.op   = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
    r.size = 16'($urandom_range(0, 48));
    r.alog = 4'($urandom_range(0, 4));
    if (wide) begin
      case ($urandom_range(0, 9))
        0: r.size = 16'($urandom);
        1: r.size = 16'hFFFF;
        2: r.alog = 4'($urandom_range(0, 15));
        3: r.alog = 4'($urandom_range(8, 15));
        default: ;
      endcase
    end
    r.skew = ($urandom_range(0, 1) != 0) ? 12'($urandom) : 12'($urandom_range(0, 7));
    r.addr = $urandom;
    if (r.op == OP_FREE && live_blocks != 0) begin
      case ($urandom_range(0, 9))
        0: ;
        1: r.addr = newest_data_address() ^ (32'd1 << $urandom_range(0, 31));
        default: r.addr = newest_data_address();
      endcase
    end
    return r;
  endfunction

  // Offer one request after a random gap and log its expected reply on acceptance
  task automatic offer(input request_t r, input bit typed, input reply_t want);
    reply_t predicted;
    int     gap;
    if ($urandom_range(0, 39) == 0) tx_idle_on = !tx_idle_on;
    gap = tx_idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    opcode_i         <= r.op;
    size_i           <= r.size;
    alignment_log2_i <= r.alog;
    skew_i           <= r.skew;
    address_i        <= r.addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = apply_request(r);
    pending_replies.push_back(typed ? want : predicted);
  endtask

  // Write both registers once the allocator has drained
  task automatic configure(input logic [ADDR_W-1:0] base, input logic [ARENA_W-1:0] arena);
    logic [ADDR_W-1:0] vals [2];
    vals[0] = base;
    vals[1] = {{(ADDR_W-ARENA_W){1'b0}}, arena};
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    for (int k = 0; k < 2; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= (k == 0) ? CFG_BASE_ADDRESS : CFG_ARENA_BYTES;
      cfg_data_i  <= vals[k];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    cfg_base  = base;
    cfg_arena = arena;
  endtask

  // Result side: random stalls, one long hold-off, compare each transaction
  initial begin : result_sink
    reply_t got;
    reply_t want;
    int     hold;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_idle_on = !rx_idle_on;
      if (results_seen == 400) hold = 150;
      else hold = rx_idle_on ? $urandom_range(0, 6) : 0;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got.addr   = result_address_o;
      got.status = status_o;
      got.used   = used_bytes_o;
      results_seen++;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result: address %h status %0d used_bytes %0d",
                 $time, got.addr, got.status, got.used);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (got.addr !== want.addr) begin
          $display("%0t: result_address expected %h actual %h", $time, want.addr, got.addr);
          mismatches++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          mismatches++;
        end
        if (got.used !== want.used) begin
          $display("%0t: used_bytes expected %0d actual %0d", $time, want.used, got.used);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    request_t r;
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    opcode_i         = 1'b0;
    size_i           = '0;
    alignment_log2_i = '0;
    skew_i           = '0;
    address_i        = '0;
    out_stall_i      = 1'b0;
    cfg_base         = '0;
    cfg_arena        = 17'd65536;
    top_ofs          = '0;
    live_blocks      = 0;
    mismatches       = 0;
    results_seen     = 0;
    tx_idle_on       = 1'b1;
    rx_idle_on       = 1'b1;

    // Reset defaults, extremes, both header alignments above range, LIFO errors
    dir_rows = '{
      '{'{OP_FREE,  16'd0,     4'd0,  12'd0,   32'd0},  1'b0, 1'b1,
        '{32'd0, STAT_NOT_NEWEST, 17'd0}},
      '{'{OP_ALLOC, 16'd0,     4'd0,  12'd0,   32'd0},  1'b0, 1'b1,
        '{32'd8, STAT_OK, 17'd8}},
      '{'{OP_FREE,  16'hFFFF,  4'hF,  12'hFFF, 32'd8},  1'b0, 1'b1,
        '{32'd0, STAT_OK, 17'd0}},
      '{'{OP_ALLOC, 16'hFFFF,  4'd0,  12'd0,   32'hFFFF_FFFF}, 1'b0, 1'b1,
        '{32'd0, STAT_OVERFLOW, 17'd0}},
      '{'{OP_ALLOC, 16'd65528, 4'd0,  12'd0,   32'd0},  1'b0, 1'b1,
        '{32'd8, STAT_OK, 17'd65536}},
      '{'{OP_ALLOC, 16'd0,     4'd0,  12'd0,   32'd0},  1'b0, 1'b1,
        '{32'd0, STAT_OVERFLOW, 17'd65536}},
      '{'{OP_FREE,  16'd0,     4'd0,  12'd0,   32'hFFFF_FFFF}, 1'b0, 1'b1,
        '{32'd0, STAT_NOT_NEWEST, 17'd65536}},
      '{'{OP_FREE,  16'd0,     4'd0,  12'd0,   32'd8},  1'b0, 1'b1,
        '{32'd0, STAT_OK, 17'd0}},
      '{'{OP_ALLOC, 16'd5,     4'd12, 12'd4095, 32'd0}, 1'b0, 1'b0, '0},
      '{'{OP_ALLOC, 16'd100,   4'd15, 12'd0,   32'd0},  1'b0, 1'b0, '0},
      '{'{OP_ALLOC, 16'd3,     4'd13, 12'd7,   32'd0},  1'b0, 1'b0, '0},
      '{'{OP_ALLOC, 16'd0,     4'd14, 12'd1,   32'd0},  1'b0, 1'b0, '0},
      '{'{OP_FREE,  16'd0,     4'd0,  12'd0,   32'd9},  1'b0, 1'b0, '0},
      '{'{OP_FREE,  16'd0,     4'd0,  12'd0,   32'd0},  1'b1, 1'b0, '0},
      '{'{OP_FREE,  16'd0,     4'd0,  12'd0,   32'd0},  1'b1, 1'b0, '0},
      '{'{OP_ALLOC, 16'h8000,  4'd3,  12'h800, 32'd0},  1'b0, 1'b0, '0},
      '{'{OP_FREE,  16'd0,     4'd0,  12'd0,   32'd0},  1'b1, 1'b0, '0},
      '{'{OP_FREE,  16'd0,     4'd0,  12'd0,   32'd0},  1'b1, 1'b0, '0},
      '{'{OP_FREE,  16'd0,     4'd0,  12'd0,   32'd0},  1'b0, 1'b0, '0}
    };

    // Base and limit per phase: wrap at the top of the address space, empty
    // arena, store filled to capacity, limit below the live top
    phases = '{
      '{32'h1000_0000, 17'd65536, 200, 60, 1'b1},
      '{32'hFFFF_FFF0, 17'd4096,  150, 55, 1'b1},
      '{32'h0000_0000, 17'd0,      40, 50, 1'b1},
      '{32'h0000_0000, 17'd65536, 260, 85, 1'b0},
      '{32'h8000_0001, 17'd300,   150, 50, 1'b0},
      '{32'hFFFF_FFFF, 17'd65536, 250, 50, 1'b1}
    };
    phases[2].base = $urandom;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows against reset configuration
    for (int i = 0; i < NUM_ROWS; i++) begin
      r = dir_rows[i].req;
      if (dir_rows[i].to_newest) r.addr = newest_data_address();
      offer(r, dir_rows[i].typed, dir_rows[i].want);
    end
    in_valid_i <= 1'b0;

    // Random phases; state carries over across register changes
    for (int p = 0; p < NUM_PHASES; p++) begin
      configure(phases[p].base, phases[p].arena);
      for (int i = 0; i < phases[p].items; i++)
        offer(draw_request(phases[p].alloc_pct, phases[p].wide), 1'b0, '0);
      in_valid_i <= 1'b0;
    end

    // Drain, then give stray results time to show up
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("stack_allocator_with_headers verification clean");
    end else begin
      $display("stack_allocator_with_headers verification failed");
    end
    $finish;
  end

endmodule
